FILE: rtl/core/mlft_pkg.sv
// constants, codes and types shared by the learning table modules
package mlft_pkg;

	localparam int TABLE_ENTRIES = 256;
	localparam int SWITCH_COUNT  = 16;
	localparam int IDX_W         = $clog2(TABLE_ENTRIES);

	localparam int OP_W     = 2;
	localparam int SW_W     = 4;
	localparam int REASON_W = 2;
	localparam int PORT_W   = 32;
	localparam int MAC_W    = 48;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 3;
	localparam int SW_CMP_W = 9;

	localparam logic [OP_W-1:0] OP_PACKET_IN    = 2'd0;
	localparam logic [OP_W-1:0] OP_FLOW_REMOVED = 2'd1;
	localparam logic [OP_W-1:0] OP_ATTACH       = 2'd2;

	localparam logic [REASON_W-1:0] REASON_NO_MATCH = 2'd0;
	localparam logic [REASON_W-1:0] REASON_ACTION   = 2'd1;

	localparam logic [STATUS_W-1:0] STATUS_OK        = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_NO_TABLE  = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_MISMATCH  = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_BCAST_SRC = 3'd4;

	localparam logic [PORT_W-1:0] FLOOD_PORT     = 32'hFFFF_FFFB;
	localparam logic [MAC_W-1:0]  BROADCAST_MAC  = 48'hFFFF_FFFF_FFFF;
	localparam logic [WORD_W-1:0] PRIORITY_START = 32'd100;

	typedef struct packed {
		logic [SW_W-1:0]   sw;
		logic [MAC_W-1:0]  mac;
		logic [PORT_W-1:0] port;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic capture;
		logic attach;
		logic scan_start;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            reason_ok;
		logic            present;
		logic            scan_done;
		logic            out_free;
	} ctl_status_t;

endpackage

FILE: rtl/core/mlft_ram.sv
// generic single write port ram with registered read
module mlft_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [WIDTH-1:0]  wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

FILE: rtl/core/mlft_ctrl.sv
// controller state machine for the learning table
module mlft_ctrl
	import mlft_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  ctl_status_t stat,
	output ctl_cmd_t    cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				state_d = ST_IDLE;
				case (stat.op)
					OP_ATTACH: begin
						cmd.attach = 1'b1;
					end
					OP_FLOW_REMOVED: begin
						if (stat.present) begin
							cmd.scan_start = 1'b1;
							state_d        = ST_SCAN;
						end
					end
					OP_PACKET_IN: begin
						if (stat.reason_ok) begin
							if (stat.present) begin
								cmd.scan_start = 1'b1;
								state_d        = ST_SCAN;
							end else begin
								state_d = ST_FINISH;
							end
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_SCAN: begin
				if (stat.scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (stat.op != OP_PACKET_IN || stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/mlft_dpath.sv
// datapath: input registers, table scan, learning, erasure and result register
module mlft_dpath
	import mlft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  ctl_cmd_t            cmd,
	output ctl_status_t         stat,
	input  logic [OP_W-1:0]     operation,
	input  logic [SW_W-1:0]     switch_index,
	input  logic [REASON_W-1:0] reason,
	input  logic [PORT_W-1:0]   in_port,
	input  logic [MAC_W-1:0]    src_mac,
	input  logic [MAC_W-1:0]    dst_mac,
	input  logic [WORD_W-1:0]   buffer_ref,
	input  logic [WORD_W-1:0]   transaction_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PORT_W-1:0]   out_port,
	output logic [PORT_W-1:0]   reply_in_port,
	output logic [WORD_W-1:0]   reply_buffer,
	output logic [WORD_W-1:0]   reply_transaction,
	output logic                learned_new,
	output logic [WORD_W-1:0]   flow_priority,
	output logic [STATUS_W-1:0] status
);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	logic [OP_W-1:0]     op_q;
	logic [SW_W-1:0]     sw_q;
	logic [REASON_W-1:0] reason_q;
	logic [PORT_W-1:0]   in_port_q;
	logic [MAC_W-1:0]    src_q;
	logic [MAC_W-1:0]    dst_q;
	logic [WORD_W-1:0]   buf_q;
	logic [WORD_W-1:0]   xid_q;

	logic [SWITCH_COUNT-1:0]  present_q;
	logic [TABLE_ENTRIES-1:0] entry_valid_q;
	logic [WORD_W-1:0]        prio_q;

	logic             issue_q;
	logic [IDX_W-1:0] addr_q;
	logic             valid_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             ev_s1;

	logic              dst_found_q;
	logic [IDX_W-1:0]  dst_idx_q;
	logic [PORT_W-1:0] dst_port_q;
	logic              src_found_q;
	logic [PORT_W-1:0] src_port_q;
	logic              free_found_q;
	logic [IDX_W-1:0]  free_idx_q;

	logic out_valid_q;

	entry_t rd_entry;
	entry_t wr_entry;
	logic   sw_in_range;
	logic   present;
	logic   hit_dst;
	logic   hit_src;
	logic   is_free;
	logic   finish_pkt;
	logic   learn;
	logic   erase;

	logic [PORT_W-1:0]   res_port;
	logic [STATUS_W-1:0] res_status;
	logic [WORD_W-1:0]   prio_next;

	mlft_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_ram (
		.clk    (clk),
		.wr_en  (learn),
		.wr_addr(free_idx_q),
		.wr_data(wr_entry),
		.rd_en  (issue_q),
		.rd_addr(addr_q),
		.rd_data(rd_entry)
	);

	assign sw_in_range = SW_CMP_W'(sw_q) < SW_CMP_W'(SWITCH_COUNT);
	assign present     = sw_in_range && present_q[sw_q];
	assign wr_entry    = '{sw: sw_q, mac: src_q, port: in_port_q};

	assign hit_dst = valid_s1 && ev_s1 && (rd_entry.sw == sw_q) && (rd_entry.mac == dst_q);
	assign hit_src = valid_s1 && ev_s1 && (rd_entry.sw == sw_q) && (rd_entry.mac == src_q);
	assign is_free = valid_s1 && !ev_s1;

	assign stat.op        = op_q;
	assign stat.reason_ok = (reason_q == REASON_NO_MATCH) || (reason_q == REASON_ACTION);
	assign stat.present   = present;
	assign stat.scan_done = valid_s1 && (idx_s1 == LAST_IDX);
	assign stat.out_free  = !out_valid_q || out_ready;

	assign finish_pkt = cmd.finish && (op_q == OP_PACKET_IN);
	assign prio_next  = prio_q + WORD_W'(1);

	always_comb begin
		learn      = 1'b0;
		res_status = STATUS_OK;
		res_port   = FLOOD_PORT;
		if (!present) begin
			res_status = STATUS_NO_TABLE;
		end else begin
			if (dst_q != BROADCAST_MAC && dst_found_q) begin
				res_port = dst_port_q;
			end
			if (src_q == BROADCAST_MAC) begin
				res_status = STATUS_BCAST_SRC;
			end else if (src_found_q) begin
				if (src_port_q != in_port_q) begin
					res_status = STATUS_MISMATCH;
				end
			end else if (free_found_q) begin
				learn = finish_pkt;
			end else begin
				res_status = STATUS_FULL;
			end
		end
	end

	assign erase = cmd.finish && (op_q == OP_FLOW_REMOVED) && present && dst_found_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q      <= operation;
			sw_q      <= switch_index;
			reason_q  <= reason;
			in_port_q <= in_port;
			src_q     <= src_mac;
			dst_q     <= dst_mac;
			buf_q     <= buffer_ref;
			xid_q     <= transaction_id;
		end
		idx_s1 <= addr_q;
		ev_s1  <= entry_valid_q[addr_q];
		if (hit_dst && !dst_found_q) begin
			dst_idx_q  <= idx_s1;
			dst_port_q <= rd_entry.port;
		end
		if (hit_src && !src_found_q) begin
			src_port_q <= rd_entry.port;
		end
		if (is_free && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (finish_pkt) begin
			out_port          <= res_port;
			reply_in_port     <= in_port_q;
			reply_buffer      <= buf_q;
			reply_transaction <= xid_q;
			learned_new       <= learn;
			flow_priority     <= learn ? prio_next : '0;
			status            <= res_status;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q     <= '0;
			entry_valid_q <= '0;
			prio_q        <= PRIORITY_START;
			issue_q       <= 1'b0;
			addr_q        <= '0;
			valid_s1      <= 1'b0;
			dst_found_q   <= 1'b0;
			src_found_q   <= 1'b0;
			free_found_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cmd.attach && sw_in_range) begin
				present_q[sw_q] <= 1'b1;
			end
			if (learn) begin
				entry_valid_q[free_idx_q] <= 1'b1;
				prio_q                    <= prio_next;
			end
			if (erase) begin
				entry_valid_q[dst_idx_q] <= 1'b0;
			end
			valid_s1 <= issue_q;
			if (cmd.scan_start) begin
				issue_q      <= 1'b1;
				addr_q       <= '0;
				dst_found_q  <= 1'b0;
				src_found_q  <= 1'b0;
				free_found_q <= 1'b0;
			end else begin
				if (issue_q) begin
					addr_q <= addr_q + IDX_W'(1);
					if (addr_q == LAST_IDX) begin
						issue_q <= 1'b0;
					end
				end
				if (hit_dst) begin
					dst_found_q <= 1'b1;
				end
				if (hit_src) begin
					src_found_q <= 1'b1;
				end
				if (is_free) begin
					free_found_q <= 1'b1;
				end
			end
			if (finish_pkt) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: rtl/core/mac_learning_forwarding_table.sv
// top level of the shared l2 learning and forwarding table
// One transaction is taken at a time. A switch attach completes in the decode step, as does an
// ignored transaction. A packet-in or flow removed for a present switch scans every table entry
// through the single read port of the entry memory, one entry a cycle; a packet-in for a switch
// without a table goes from the decode step straight to the finish step. The scan finds the
// destination, the source and the lowest free entry in one pass. A finished result waits in an
// output register; the next transaction is taken meanwhile and only holds in its last step if the
// previous result has not yet been taken. The valid bits clear at reset, so no clearing pass is
// needed.
module mac_learning_forwarding_table
	import mlft_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [OP_W-1:0]     operation,
	input  logic [SW_W-1:0]     switch_index,
	input  logic [REASON_W-1:0] reason,
	input  logic [PORT_W-1:0]   in_port,
	input  logic [MAC_W-1:0]    src_mac,
	input  logic [MAC_W-1:0]    dst_mac,
	input  logic [WORD_W-1:0]   buffer_ref,
	input  logic [WORD_W-1:0]   transaction_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [PORT_W-1:0]   out_port,
	output logic [PORT_W-1:0]   reply_in_port,
	output logic [WORD_W-1:0]   reply_buffer,
	output logic [WORD_W-1:0]   reply_transaction,
	output logic                learned_new,
	output logic [WORD_W-1:0]   flow_priority,
	output logic [STATUS_W-1:0] status
);

	ctl_cmd_t    cmd;
	ctl_status_t stat;

	mlft_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	mlft_dpath u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.stat             (stat),
		.operation        (operation),
		.switch_index     (switch_index),
		.reason           (reason),
		.in_port          (in_port),
		.src_mac          (src_mac),
		.dst_mac          (dst_mac),
		.buffer_ref       (buffer_ref),
		.transaction_id   (transaction_id),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.out_port         (out_port),
		.reply_in_port    (reply_in_port),
		.reply_buffer     (reply_buffer),
		.reply_transaction(reply_transaction),
		.learned_new      (learned_new),
		.flow_priority    (flow_priority),
		.status           (status)
	);

endmodule
